// ===== hdl/smft_pkg.sv =====
// Shared types and constants for the sparse matrix fast transpose block.
`default_nettype none
package smft_pkg;

  // Fixed field widths of one term, the dimension registers and the configuration port.
  localparam int IDX_W = 6;
  localparam int VAL_W = 32;
  localparam int CFG_W = 7;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // Register indexes, taken from paddr[2].
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  // Reset value of both dimension registers.
  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  // One stored term.
  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } term_t;

  localparam int TERM_W = $bits(term_t);

  // One classified request passed from the front end to the back end.
  typedef struct packed {
    logic  store;
    logic  last;
    logic  drop;
    term_t term;
  } q_entry_t;

endpackage
`default_nettype wire

// ===== hdl/smft_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module smft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the written address sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/smft_front.sv =====
// Front end: configuration registers and classification of incoming requests.
`default_nettype none
module smft_front
  import smft_pkg::*;
#(
  parameter int MAX_TERMS = 64,
  parameter int MAX_DIM   = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_AW-1:0]       paddr,
  input  wire logic [APB_DW-1:0]       pwdata,
  output logic      [APB_DW-1:0]       prdata,
  output logic                         pready,
  // Input channel
  input  wire logic                    push,
  output logic                         full,
  input  wire logic                    has_term,
  input  wire logic [IDX_W-1:0]        term_row,
  input  wire logic [IDX_W-1:0]        term_col,
  input  wire logic signed [VAL_W-1:0] term_value,
  input  wire logic                    last_term,
  // Queue toward the back end
  output logic                         q_push,
  output q_entry_t                     q_entry,
  input  wire logic                    q_full
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam logic [CFG_W-1:0] DIM_MAX = CFG_W'(MAX_DIM);
  localparam logic [CNT_W-1:0] TERMS_MAX = CNT_W'(MAX_TERMS);

  logic [CFG_W-1:0] num_rows;
  logic [CFG_W-1:0] num_cols;
  logic [CNT_W-1:0] count;
  logic             drop_flag;

  logic [CFG_W-1:0] eff_rows;
  logic [CFG_W-1:0] eff_cols;
  logic             accept;
  logic             store;
  logic             drop_now;

  // Register writes land on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= DIM_RESET;
      num_cols <= DIM_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_NUM_COLS) begin
        num_cols <= pwdata[CFG_W-1:0];
      end else begin
        num_rows <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NUM_COLS) ? APB_DW'(num_cols) : APB_DW'(num_rows);

  // Dimensions above the supported size saturate.
  assign eff_rows = (num_rows > DIM_MAX) ? DIM_MAX : num_rows;
  assign eff_cols = (num_cols > DIM_MAX) ? DIM_MAX : num_cols;

  // Classify the request: keep it, or drop it as out of range or overflow.
  assign accept   = push && !full;
  assign store    = has_term && ({1'b0, term_row} < eff_rows) &&
                    ({1'b0, term_col} < eff_cols) && (count < TERMS_MAX);
  assign drop_now = has_term && !store;

  assign full             = q_full;
  assign q_push           = accept && (store || last_term);
  assign q_entry.store    = store;
  assign q_entry.last     = last_term;
  assign q_entry.drop     = drop_flag || drop_now;
  assign q_entry.term.row   = term_row;
  assign q_entry.term.col   = term_col;
  assign q_entry.term.value = term_value;

  // Per-matrix term count and sticky drop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      drop_flag <= 1'b0;
    end else if (accept) begin
      if (last_term) begin
        count     <= '0;
        drop_flag <= 1'b0;
      end else begin
        if (store) begin
          count <= CNT_W'(count + 1'b1);
        end
        drop_flag <= drop_flag || drop_now;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/smft_queue.sv =====
// Short queue of classified requests between front end and back end.
`default_nettype none
module smft_queue
  import smft_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t entry_in,
  output logic          full,
  input  wire logic     pop,
  output q_entry_t      entry_out,
  output logic          empty
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  q_entry_t        slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;
  logic            do_push;
  logic            do_pop;

  assign full      = (fill == CW'(DEPTH));
  assign empty     = (fill == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign entry_out = slots[rd_ptr];

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : AW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : AW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        fill <= CW'(fill + 1'b1);
      end else if (do_pop && !do_push) begin
        fill <= CW'(fill - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/smft_back.sv =====
// Back end: term store, column counts, prefix sum, scatter and result emission.
`default_nettype none
module smft_back
  import smft_pkg::*;
#(
  parameter int MAX_TERMS = 64,
  parameter int MAX_DIM   = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Queue from the front end
  input  wire logic                    q_empty,
  input  wire q_entry_t                q_entry,
  output logic                         q_pop,
  // Result channel
  output logic                         empty,
  input  wire logic                    pop,
  output logic [IDX_W-1:0]             out_row,
  output logic [IDX_W-1:0]             out_col,
  output logic signed [VAL_W-1:0]      out_value,
  output logic                         out_last,
  output logic                         dropped
);

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int TAW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int DAW   = $clog2(MAX_DIM);
  localparam logic [DAW:0]   DIM_END  = (DAW + 1)'(MAX_DIM);
  localparam logic [DAW-1:0] DIM_LAST = DAW'(MAX_DIM - 1);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_FLUSH,
    ST_PFX,
    ST_SC_SRC,
    ST_SC_START,
    ST_SC_WR,
    ST_EM_RD,
    ST_EM_LD,
    ST_EM_WAIT
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    n;
  logic                drop_b;
  logic [CNT_W-1:0]    j;
  // Count update pipeline stage and its bypass.
  logic                b_valid;
  logic [DAW-1:0]      b_col;
  logic                wr_d;
  logic [DAW-1:0]      col_d;
  logic [CNT_W-1:0]    val_d;
  logic [MAX_DIM-1:0]  cvalid;
  // Prefix sweep.
  logic [DAW:0]        ra;
  logic                p_valid;
  logic [DAW-1:0]      p_idx;
  logic [CNT_W-1:0]    acc;
  logic                out_valid;

  // Memory ports.
  logic                src_we;
  logic                src_re;
  logic [TAW-1:0]      src_raddr;
  logic [TERM_W-1:0]   src_rraw;
  term_t               src_rd;
  logic                cnt_we;
  logic [DAW-1:0]      cnt_waddr;
  logic [CNT_W-1:0]    cnt_wdata;
  logic                cnt_re;
  logic [DAW-1:0]      cnt_raddr;
  logic [CNT_W-1:0]    cnt_rdata;
  logic                res_we;
  term_t               res_wd;
  logic                res_re;
  logic [TERM_W-1:0]   res_rraw;
  term_t               res_rd;

  logic [CNT_W-1:0]    b_base;
  logic [CNT_W-1:0]    b_next;
  logic [CNT_W-1:0]    p_cnt;
  logic [CNT_W-1:0]    n_last;

  assign src_rd = term_t'(src_rraw);
  assign res_rd = term_t'(res_rraw);
  assign n_last = CNT_W'(n - 1'b1);

  // Pop a waiting request whenever the load phase is running.
  assign q_pop  = (state == ST_LOAD) && !q_empty;
  assign src_we = q_pop && q_entry.store;

  // Counter value for the update stage, with bypass of the previous write.
  assign b_base = (wr_d && (col_d == b_col)) ? val_d :
                  (cvalid[b_col] ? cnt_rdata : '0);
  assign b_next = CNT_W'(b_base + 1'b1);
  assign p_cnt  = cvalid[p_idx] ? cnt_rdata : '0;

  // Scattered term has row and column swapped.
  assign res_wd.row   = src_rd.col;
  assign res_wd.col   = src_rd.row;
  assign res_wd.value = src_rd.value;

  // Port steering by phase.
  always_comb begin
    src_re    = 1'b0;
    src_raddr = j[TAW-1:0];
    cnt_we    = b_valid;
    cnt_waddr = b_col;
    cnt_wdata = b_next;
    cnt_re    = 1'b0;
    cnt_raddr = q_entry.term.col[DAW-1:0];
    res_we    = 1'b0;
    res_re    = 1'b0;
    case (state)
      ST_LOAD: begin
        cnt_re = src_we;
      end
      ST_PFX: begin
        cnt_re    = (ra < DIM_END);
        cnt_raddr = ra[DAW-1:0];
        cnt_we    = p_valid;
        cnt_waddr = p_idx;
        cnt_wdata = acc;
      end
      ST_SC_SRC: begin
        src_re = 1'b1;
      end
      ST_SC_START: begin
        cnt_re    = 1'b1;
        cnt_raddr = src_rd.col[DAW-1:0];
      end
      ST_SC_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = src_rd.col[DAW-1:0];
        cnt_wdata = CNT_W'(cnt_rdata + 1'b1);
        res_we    = 1'b1;
      end
      ST_EM_RD: begin
        res_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  smft_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (n[TAW-1:0]),
    .wdata (q_entry.term),
    .re    (src_re),
    .raddr (src_raddr),
    .rdata (src_rraw)
  );

  smft_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DIM)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  smft_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_res_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (cnt_rdata[TAW-1:0]),
    .wdata (res_wd),
    .re    (res_re),
    .raddr (j[TAW-1:0]),
    .rdata (res_rraw)
  );

  assign empty = !out_valid;

  // Sequencer with the count pipeline and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      n         <= '0;
      j         <= '0;
      b_valid   <= 1'b0;
      wr_d      <= 1'b0;
      cvalid    <= '0;
      ra        <= '0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      b_valid <= src_we;
      b_col   <= q_entry.term.col[DAW-1:0];
      wr_d    <= b_valid;
      col_d   <= b_col;
      val_d   <= b_next;
      if (b_valid) begin
        cvalid[b_col] <= 1'b1;
      end
      case (state)
        ST_LOAD: begin
          if (q_pop) begin
            if (q_entry.store) begin
              n <= CNT_W'(n + 1'b1);
            end
            if (q_entry.last) begin
              drop_b <= q_entry.drop;
              state  <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          ra      <= '0;
          p_valid <= 1'b0;
          acc     <= '0;
          state   <= (n == '0) ? ST_LOAD : ST_PFX;
        end
        ST_PFX: begin
          // The sweep address has passed the end when the last column is written.
          if (ra < DIM_END) begin
            ra <= (DAW + 1)'(ra + 1'b1);
          end
          p_valid <= (ra < DIM_END);
          p_idx   <= ra[DAW-1:0];
          if (p_valid) begin
            acc <= CNT_W'(acc + p_cnt);
            if (p_idx == DIM_LAST) begin
              cvalid  <= '0;
              j       <= '0;
              state   <= ST_SC_SRC;
            end
          end
        end
        ST_SC_SRC: begin
          state <= ST_SC_START;
        end
        ST_SC_START: begin
          state <= ST_SC_WR;
        end
        ST_SC_WR: begin
          if (j == n_last) begin
            j     <= '0;
            state <= ST_EM_RD;
          end else begin
            j     <= CNT_W'(j + 1'b1);
            state <= ST_SC_SRC;
          end
        end
        ST_EM_RD: begin
          state <= ST_EM_LD;
        end
        ST_EM_LD: begin
          out_row   <= res_rd.row;
          out_col   <= res_rd.col;
          out_value <= res_rd.value;
          out_last  <= (j == n_last);
          dropped   <= drop_b;
          out_valid <= 1'b1;
          state     <= ST_EM_WAIT;
        end
        ST_EM_WAIT: begin
          if (pop) begin
            out_valid <= 1'b0;
            if (j == n_last) begin
              n     <= '0;
              j     <= '0;
              state <= ST_LOAD;
            end else begin
              j     <= CNT_W'(j + 1'b1);
              state <= ST_EM_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sparse_matrix_fast_transpose_top.sv =====
// Top level of the sparse matrix fast transpose block.
//
// Terms of a sparse matrix enter through a queue-style port (push/full), one
// term per request, until a request with last_term set. Terms outside the
// num_rows by num_cols window, or beyond MAX_TERMS stored terms, are dropped
// and flagged on every result of that matrix. A request with has_term low
// only closes the matrix when last_term is set.
// Results leave through a queue-style port (empty/pop) sorted by source
// column, row and column swapped, out_last on the final one.
// Loading accepts one request per cycle; a short queue decouples the input
// from the term store, so input stalls only once the queue fills while a
// previous matrix is still being transposed.
// After the last request the block runs the column count prefix sweep, then
// the scatter of each stored term (source read, column start read, result
// write, each step waiting on the registered read before it), then emits
// each result: result memory read, output register load, hand-off.
// A stalled receiver holds the current result and pauses emission.
// Reset (rst, synchronous) empties the queue, clears the counts and sets
// both dimension registers to 64. Configuration is written over APB.
`default_nettype none
module sparse_matrix_fast_transpose_top
  import smft_pkg::*;
#(
  parameter int MAX_TERMS   = 64,
  parameter int MAX_DIM     = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_AW-1:0]       paddr,
  input  wire logic [APB_DW-1:0]       pwdata,
  output logic      [APB_DW-1:0]       prdata,
  output logic                         pready,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic                    has_term,
  input  wire logic [IDX_W-1:0]        term_row,
  input  wire logic [IDX_W-1:0]        term_col,
  input  wire logic signed [VAL_W-1:0] term_value,
  input  wire logic                    last_term,
  output logic                         empty,
  input  wire logic                    pop,
  output logic [IDX_W-1:0]             out_row,
  output logic [IDX_W-1:0]             out_col,
  output logic signed [VAL_W-1:0]      out_value,
  output logic                         out_last,
  output logic                         dropped
);

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  q_entry_t q_in;
  q_entry_t q_out;

  // Classification and configuration.
  smft_front #(.MAX_TERMS(MAX_TERMS), .MAX_DIM(MAX_DIM)) u_front (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .has_term   (has_term),
    .term_row   (term_row),
    .term_col   (term_col),
    .term_value (term_value),
    .last_term  (last_term),
    .q_push     (q_push),
    .q_entry    (q_in),
    .q_full     (q_full)
  );

  // Decoupling queue.
  smft_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .entry_out (q_out),
    .empty     (q_empty)
  );

  // Store, transpose and emit.
  smft_back #(.MAX_TERMS(MAX_TERMS), .MAX_DIM(MAX_DIM)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_entry   (q_out),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last),
    .dropped   (dropped)
  );

endmodule
`default_nettype wire

// ===== hdl/smft_checker.sv =====
// Port-level checker for the sparse matrix fast transpose block and its bind.
`default_nettype none
module smft_checker
  import smft_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    full,
  input wire logic                    empty,
  input wire logic                    pop,
  input wire logic [IDX_W-1:0]        out_row,
  input wire logic [IDX_W-1:0]        out_col,
  input wire logic signed [VAL_W-1:0] out_value,
  input wire logic                    out_last,
  input wire logic                    dropped
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting right after reset");

  // Reset leaves the input queue with room.
  a_reset_room: assert property (@(posedge clk) rst |=> !full)
    else $error("input full right after reset");

  // Each result is fetched from memory anew, so a taken result is never followed at once.
  a_gap_after_pop: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) |=> empty)
    else $error("result shown in the cycle after a pop");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_row) && $stable(out_col) &&
                          $stable(out_value) && $stable(out_last) && $stable(dropped)))
    else $error("stalled result changed");

endmodule

bind sparse_matrix_fast_transpose_top smft_checker u_checker (.*);
`default_nettype wire
